[hw/rtl/awbp_pkg.sv]
// ----------------------------------------------------------------------------
// awbp_pkg
// shared constants for the packed bilinear affine warp core
// ----------------------------------------------------------------------------
package awbp_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
   localparam logic [2:0] REG_SRC_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_COS_TERM    = 3'd2;
   localparam logic [2:0] REG_SIN_TERM    = 3'd3;
   localparam logic [2:0] REG_ORIGIN_X    = 3'd4;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd5;
   localparam logic [2:0] REG_CROP_BLACK  = 3'd6;
   localparam logic [2:0] REG_ROTATE_MODE = 3'd7;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 21;

   // input word operation codes
   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_PRODUCE = 1'b1;

   // integer pixel coordinate, signed
   localparam int COORD_BITS = 15;

   localparam logic [7:0] CROP_FILL = 8'd16;
   localparam logic [7:0] BYTE_MAX  = 8'd255;

   typedef logic signed [COORD_BITS-1:0] coord_type;

endpackage

[hw/rtl/awbp_if.sv]
// ----------------------------------------------------------------------------
// awbp channel interfaces
// request and response channels of the warp core
// ----------------------------------------------------------------------------
interface awbp_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] pos_x;
   logic [7:0] pos_y;
   logic [1:0] chan;
   logic [7:0] byte_in;

   modport source (output valid, mode, pos_x, pos_y, chan, byte_in, input ready);
   modport sink   (input valid, mode, pos_x, pos_y, chan, byte_in, output ready);
endinterface

interface awbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;

   modport source (output valid, pixel_out, input ready);
   modport sink   (input valid, pixel_out, output ready);
endinterface

[hw/rtl/awbp_ram.sv]
// ----------------------------------------------------------------------------
// awbp_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module awbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/affine_warp_bilinear_packed_core.sv]
// ----------------------------------------------------------------------------
// affine_warp_bilinear_packed_core
// affine image warp with bilinear sampling over an interleaved byte frame
// ----------------------------------------------------------------------------
// Load words write one byte of the source frame; produce words return one
// destination byte each. The core takes one word per clock while its skid
// buffer is empty. A produce result passes six register stages (input
// products, coordinate sum, integer/fraction split, frame read, horizontal
// blend, vertical blend into the output register) and is then offered on the
// response channel. The frame sits in four ram banks split by the parity of
// column and row, so the four bilinear neighbours are read in the same cycle
// through one read port per bank. A load writes the frame in the read
// stage, so a produce word that follows it sees the new byte. The frame has
// no reset and must be loaded before it is sampled. A one-word skid buffer
// behind the output register lets the core keep taking words while a result
// waits; when the skid buffer fills the whole pipeline holds.
// ----------------------------------------------------------------------------
module affine_warp_bilinear_packed_core
   import awbp_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CHANNELS   = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   awbp_req_if.sink                  req_if,
   awbp_rsp_if.source                rsp_if,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // bank geometry: four banks by column and row parity
   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H * CHANNELS;
   localparam int AW         = $clog2(BANK_DEPTH);
   localparam int EW_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int EH_BITS    = $clog2(MAX_HEIGHT + 1);

   // configuration registers
   logic [8:0]         width_ff;
   logic [8:0]         height_ff;
   logic signed [15:0] cos_ff;
   logic signed [15:0] sin_ff;
   logic signed [20:0] origin_x_ff;
   logic signed [20:0] origin_y_ff;
   logic               crop_ff;
   logic               rotate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 9'd256;
         height_ff   <= 9'd256;
         cos_ff      <= 16'sd16384;
         sin_ff      <= 16'sd0;
         origin_x_ff <= 21'sd0;
         origin_y_ff <= 21'sd0;
         crop_ff     <= 1'b0;
         rotate_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SRC_WIDTH:   width_ff    <= csr_wdata[8:0];
            REG_SRC_HEIGHT:  height_ff   <= csr_wdata[8:0];
            REG_COS_TERM:    cos_ff      <= csr_wdata[15:0];
            REG_SIN_TERM:    sin_ff      <= csr_wdata[15:0];
            REG_ORIGIN_X:    origin_x_ff <= csr_wdata;
            REG_ORIGIN_Y:    origin_y_ff <= csr_wdata;
            REG_CROP_BLACK:  crop_ff     <= csr_wdata[0];
            REG_ROTATE_MODE: rotate_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective frame size, clipped to the memory
   logic [EW_BITS-1:0] eff_w;
   logic [EH_BITS-1:0] eff_h;
   assign eff_w = (13'(width_ff) > 13'(MAX_WIDTH))  ? EW_BITS'(MAX_WIDTH)  : EW_BITS'(width_ff);
   assign eff_h = (13'(height_ff) > 13'(MAX_HEIGHT)) ? EH_BITS'(MAX_HEIGHT) : EH_BITS'(height_ff);

   // pipeline advance: everything holds while the skid buffer is full
   logic en;
   logic skid_valid_ff;
   assign en = !skid_valid_ff;
   assign req_if.ready = en;

   // ---------------------------------------------------------------- stage a
   // rotation products straight from the input word
   logic               a_valid_ff;
   logic               a_mode_ff;
   logic [7:0]         a_px_ff, a_py_ff, a_byte_ff;
   logic [1:0]         a_chan_ff;
   logic signed [24:0] a_cx_ff, a_sy_ff, a_sx_ff, a_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mode_ff <= req_if.mode;
         a_px_ff   <= req_if.pos_x;
         a_py_ff   <= req_if.pos_y;
         a_chan_ff <= req_if.chan;
         a_byte_ff <= req_if.byte_in;
         a_cx_ff   <= cos_ff * $signed({1'b0, req_if.pos_x});
         a_sy_ff   <= sin_ff * $signed({1'b0, req_if.pos_y});
         a_sx_ff   <= sin_ff * $signed({1'b0, req_if.pos_x});
         a_cy_ff   <= cos_ff * $signed({1'b0, req_if.pos_y});
      end
   end

   // ---------------------------------------------------------------- stage b
   // source point in q.8, floored from the exact q.14 sum
   logic signed [27:0] sum_x, sum_y;
   assign sum_x = 28'(a_cx_ff) + 28'(a_sy_ff) + (28'(origin_x_ff) <<< 6);
   assign sum_y = 28'(a_cy_ff) - 28'(a_sx_ff) + (28'(origin_y_ff) <<< 6);

   logic               b_valid_ff;
   logic               b_mode_ff;
   logic [7:0]         b_px_ff, b_py_ff, b_byte_ff;
   logic [1:0]         b_chan_ff;
   logic signed [21:0] b_xs_ff, b_ys_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_mode_ff <= a_mode_ff;
         b_px_ff   <= a_px_ff;
         b_py_ff   <= a_py_ff;
         b_chan_ff <= a_chan_ff;
         b_byte_ff <= a_byte_ff;
         b_xs_ff   <= 22'(sum_x >>> 6);
         b_ys_ff   <= 22'(sum_y >>> 6);
      end
   end

   // ---------------------------------------------------------------- stage c
   // translation offsets, rounded half away from zero
   logic [20:0] mag_x, mag_y;
   logic [21:0] rnd_mag_x, rnd_mag_y;
   coord_type   shift_x, shift_y;
   assign mag_x     = origin_x_ff[20] ? 21'(-origin_x_ff) : 21'(origin_x_ff);
   assign mag_y     = origin_y_ff[20] ? 21'(-origin_y_ff) : 21'(origin_y_ff);
   assign rnd_mag_x = (22'(mag_x) + 22'd128) >> 8;
   assign rnd_mag_y = (22'(mag_y) + 22'd128) >> 8;
   assign shift_x   = origin_x_ff[20] ? -COORD_BITS'(rnd_mag_x) : COORD_BITS'(rnd_mag_x);
   assign shift_y   = origin_y_ff[20] ? -COORD_BITS'(rnd_mag_y) : COORD_BITS'(rnd_mag_y);

   // rotated point more than a pixel outside the frame
   logic signed [21:0] lim_x, lim_y;
   logic               rot_out, chan_bad;
   assign lim_x    = signed'(22'({eff_w, 8'h00}));
   assign lim_y    = signed'(22'({eff_h, 8'h00}));
   assign rot_out  = (b_xs_ff < -22'sd256) || (b_xs_ff > lim_x) ||
                     (b_ys_ff < -22'sd256) || (b_ys_ff > lim_y);
   assign chan_bad = !({1'b0, b_chan_ff} < 3'(CHANNELS));

   logic       c_valid_ff;
   logic       c_mode_ff;
   logic [7:0] c_px_ff, c_py_ff, c_byte_ff, c_def_ff;
   logic [1:0] c_chan_ff;
   logic       c_forced_ff;
   coord_type  c_x0_ff, c_y0_ff;
   logic [7:0] c_fx_ff, c_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   // translation reuses the blend with zero fraction, which yields the top-left byte
   always_ff @(posedge clock) begin
      if (en) begin
         c_mode_ff   <= b_mode_ff;
         c_px_ff     <= b_px_ff;
         c_py_ff     <= b_py_ff;
         c_chan_ff   <= b_chan_ff;
         c_byte_ff   <= b_byte_ff;
         c_def_ff    <= crop_ff ? CROP_FILL : b_byte_ff;
         c_forced_ff <= chan_bad || (rotate_ff && rot_out);
         if (rotate_ff) begin
            c_x0_ff <= COORD_BITS'(b_xs_ff >>> 8);
            c_y0_ff <= COORD_BITS'(b_ys_ff >>> 8);
            c_fx_ff <= b_xs_ff[7:0];
            c_fy_ff <= b_ys_ff[7:0];
         end else begin
            c_x0_ff <= COORD_BITS'(b_px_ff) + shift_x;
            c_y0_ff <= COORD_BITS'(b_py_ff) + shift_y;
            c_fx_ff <= 8'd0;
            c_fy_ff <= 8'd0;
         end
      end
   end

   // ---------------------------------------------------------------- stage d
   // bank addressing and frame access
   function automatic logic [AW-1:0] bank_addr(input logic [COORD_BITS-2:0] col_half,
                                               input logic [COORD_BITS-2:0] row_half,
                                               input logic [1:0]            ch);
      logic [31:0] a;
      a = 32'(row_half) * 32'(HALF_W) + 32'(col_half);
      a = a * 32'(CHANNELS) + 32'(ch);
      return a[AW-1:0];
   endfunction

   logic      load_ok;
   logic      chan_bad_c;
   logic [AW-1:0] wr_addr;
   coord_type x1, y1;
   logic      x0_in, x1_in, y0_in, y1_in;

   assign chan_bad_c = !({1'b0, c_chan_ff} < 3'(CHANNELS));
   assign load_ok = c_valid_ff && (c_mode_ff == MODE_LOAD) && !chan_bad_c &&
                    (13'(c_px_ff) < 13'(MAX_WIDTH)) && (13'(c_py_ff) < 13'(MAX_HEIGHT));
   assign wr_addr = bank_addr((COORD_BITS-1)'(c_px_ff[7:1]), (COORD_BITS-1)'(c_py_ff[7:1]),
                              c_chan_ff);

   // a far neighbour with zero weight takes the default byte instead of memory
   assign x1    = c_x0_ff + coord_type'(1);
   assign y1    = c_y0_ff + coord_type'(1);
   assign x0_in = !c_x0_ff[COORD_BITS-1] && (c_x0_ff < $signed(COORD_BITS'(eff_w)));
   assign x1_in = !x1[COORD_BITS-1]      && (x1      < $signed(COORD_BITS'(eff_w))) &&
                  (c_fx_ff != 8'd0);
   assign y0_in = !c_y0_ff[COORD_BITS-1] && (c_y0_ff < $signed(COORD_BITS'(eff_h)));
   assign y1_in = !y1[COORD_BITS-1]      && (y1      < $signed(COORD_BITS'(eff_h))) &&
                  (c_fy_ff != 8'd0);

   logic [7:0] bank_rdata [4];
   logic [3:0] nb_valid;

   // bank index is {row parity, column parity}
   for (genvar gb = 0; gb < 4; gb++) begin : g_bank
      localparam logic BX = 1'(gb % 2);
      localparam logic BY = 1'(gb / 2);
      coord_type     col, row;
      logic          col_ok, row_ok;
      logic [AW-1:0] rd_addr;

      assign col     = (c_x0_ff[0] == BX) ? c_x0_ff : x1;
      assign row     = (c_y0_ff[0] == BY) ? c_y0_ff : y1;
      assign col_ok  = (c_x0_ff[0] == BX) ? x0_in : x1_in;
      assign row_ok  = (c_y0_ff[0] == BY) ? y0_in : y1_in;
      assign rd_addr = bank_addr(col[COORD_BITS-1:1], row[COORD_BITS-1:1], c_chan_ff);
      assign nb_valid[gb] = col_ok && row_ok;

      awbp_ram #(
         .WIDTH (8),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (en && load_ok && (c_px_ff[0] == BX) && (c_py_ff[0] == BY)),
         .wr_addr (wr_addr),
         .wr_data (c_byte_ff),
         .rd_en   (en),
         .rd_addr (rd_addr),
         .rd_data (bank_rdata[gb])
      );
   end

   logic       e_valid_ff;
   logic       e_mode_ff;
   logic       e_forced_ff;
   logic [7:0] e_def_ff, e_fx_ff, e_fy_ff;
   logic       e_xl_ff, e_yl_ff;
   logic [3:0] e_nv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_mode_ff   <= c_mode_ff;
         e_forced_ff <= c_forced_ff;
         e_def_ff    <= c_def_ff;
         e_fx_ff     <= c_fx_ff;
         e_fy_ff     <= c_fy_ff;
         e_xl_ff     <= c_x0_ff[0];
         e_yl_ff     <= c_y0_ff[0];
         e_nv_ff     <= nb_valid;
      end
   end

   // ---------------------------------------------------------------- stage e
   // neighbour selection and horizontal blend
   function automatic logic [7:0] pick(input logic [7:0] d0, input logic [7:0] d1,
                                       input logic [7:0] d2, input logic [7:0] d3,
                                       input logic [3:0] nv, input logic [7:0] dflt,
                                       input logic sx, input logic sy);
      logic [7:0] d;
      logic       ok;
      unique case ({sy, sx})
         2'b00:   begin d = d0; ok = nv[0]; end
         2'b01:   begin d = d1; ok = nv[1]; end
         2'b10:   begin d = d2; ok = nv[2]; end
         default: begin d = d3; ok = nv[3]; end
      endcase
      return ok ? d : dflt;
   endfunction

   logic [7:0]  v00, v10, v01, v11;
   logic [8:0]  wx;
   logic [16:0] h0, h1;

   assign v00 = pick(bank_rdata[0], bank_rdata[1], bank_rdata[2], bank_rdata[3], e_nv_ff,
                     e_def_ff, e_xl_ff, e_yl_ff);
   assign v10 = pick(bank_rdata[0], bank_rdata[1], bank_rdata[2], bank_rdata[3], e_nv_ff,
                     e_def_ff, !e_xl_ff, e_yl_ff);
   assign v01 = pick(bank_rdata[0], bank_rdata[1], bank_rdata[2], bank_rdata[3], e_nv_ff,
                     e_def_ff, e_xl_ff, !e_yl_ff);
   assign v11 = pick(bank_rdata[0], bank_rdata[1], bank_rdata[2], bank_rdata[3], e_nv_ff,
                     e_def_ff, !e_xl_ff, !e_yl_ff);
   assign wx  = 9'd256 - 9'(e_fx_ff);
   assign h1  = 17'(v11) * 17'(e_fx_ff) + 17'(v01) * 17'(wx);
   assign h0  = 17'(v10) * 17'(e_fx_ff) + 17'(v00) * 17'(wx);

   logic        f_valid_ff;
   logic        f_mode_ff;
   logic        f_forced_ff;
   logic [7:0]  f_def_ff, f_fy_ff;
   logic [16:0] f_h0_ff, f_h1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_mode_ff   <= e_mode_ff;
         f_forced_ff <= e_forced_ff;
         f_def_ff    <= e_def_ff;
         f_fy_ff     <= e_fy_ff;
         f_h0_ff     <= h0;
         f_h1_ff     <= h1;
      end
   end

   // ---------------------------------------------------------------- stage f
   // vertical blend, truncate and clamp
   logic [8:0]  wy;
   logic [25:0] blend;
   logic [7:0]  pixel;
   assign wy    = 9'd256 - 9'(f_fy_ff);
   assign blend = 26'(f_h1_ff) * 26'(f_fy_ff) + 26'(f_h0_ff) * 26'(wy);
   assign pixel = f_forced_ff ? f_def_ff :
                  (blend[25:24] != 2'b00) ? BYTE_MAX : blend[23:16];

   // output register and skid buffer
   logic       out_valid_ff;
   logic [7:0] out_pixel_ff, skid_pixel_ff;
   logic       take_out, new_word;
   assign take_out = out_valid_ff && rsp_if.ready;
   assign new_word = en && f_valid_ff && (f_mode_ff == MODE_PRODUCE);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take_out) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (new_word) begin
         if (!out_valid_ff || take_out) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take_out) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take_out) begin
            out_pixel_ff <= skid_pixel_ff;
         end
      end else if (new_word) begin
         if (!out_valid_ff || take_out) begin
            out_pixel_ff <= pixel;
         end else begin
            skid_pixel_ff <= pixel;
         end
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.pixel_out = out_pixel_ff;

endmodule
